### rtl/kmce_pkg.sv
// Shared types, constants and helpers of the keypad matrix change detector.
package kmce_pkg;

    localparam int MAX_ROWS    = 14;
    localparam int MAX_COLUMNS = 8;
    localparam int COLUMN_W    = 3;
    localparam int KEY_W       = 7;
    localparam int CFG_W       = 4;
    localparam int ROW_IDX_W   = $clog2(MAX_ROWS);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] ROW_COUNT_RESET    = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = CFG_W'(MAX_COLUMNS);

    typedef enum logic [0:0] {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [MAX_ROWS-1:0] row_levels;
    } reading_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic             pressed;
        logic             last;
    } key_event_t;

    // One column's worth of pending events.
    typedef struct packed {
        logic [KEY_W-1:0]    base;
        logic [MAX_ROWS-1:0] down_rows;
        logic [MAX_ROWS-1:0] up_rows;
    } job_t;

    // Rows below the row count; counts above MAX_ROWS saturate naturally.
    function automatic logic [MAX_ROWS-1:0] rows_in_use(input logic [CFG_W-1:0] n);
        logic [MAX_ROWS-1:0] m;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            m[r] = (5'(r) < {1'b0, n});
        end
        return m;
    endfunction

    // Index of the lowest set bit; zero for an empty mask.
    function automatic logic [ROW_IDX_W-1:0] lowest_set(input logic [MAX_ROWS-1:0] m);
        logic [ROW_IDX_W-1:0] idx;
        idx = '0;
        for (int r = MAX_ROWS - 1; r >= 0; r--)
        begin
            if (m[r])
            begin
                idx = ROW_IDX_W'(r);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/kmce_front.sv
// Front end: configuration, per-column mask store and change classification.
module kmce_front
    import kmce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  cfg_reg_t              cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  reading_valid,
    output logic                  reading_stall,
    input  reading_t              reading,
    output logic                  job_valid,
    input  logic                  job_stall,
    output job_t                  job
);

    logic [CFG_W-1:0]    row_count_reg;
    logic [CFG_W-1:0]    column_count_reg;
    logic [MAX_ROWS-1:0] prev_reg [MAX_COLUMNS];

    logic                accept;
    logic                in_range;
    logic [MAX_ROWS-1:0] now_mask;
    logic [MAX_ROWS-1:0] before_mask;
    logic [MAX_ROWS-1:0] changed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= ROW_COUNT_RESET;
            column_count_reg <= COLUMN_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign reading_stall = job_stall;
    assign accept        = reading_valid && !job_stall;
    assign in_range      = ({1'b0, reading.column} < column_count_reg);
    assign now_mask      = ~reading.row_levels & rows_in_use(row_count_reg);
    assign before_mask   = prev_reg[reading.column];
    assign changed       = now_mask ^ before_mask;

    // Queue a job only when the column is in use and something moved.
    assign job_valid     = reading_valid && in_range && (changed != '0);
    assign job.base      = KEY_W'(reading.column) * KEY_W'(MAX_ROWS);
    assign job.down_rows = changed & now_mask;
    assign job.up_rows   = changed & before_mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < MAX_COLUMNS; c++)
            begin
                prev_reg[c] <= '0;
            end
        end
        else if (accept && in_range)
        begin
            prev_reg[reading.column] <= now_mask;
        end
    end

endmodule

### rtl/kmce_queue.sv
// Short job queue between the front end and the event sequencer.
module kmce_queue
    import kmce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_stall,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_stall,
    output job_t pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop_valid && !pop_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### rtl/kmce_back.sv
// Back end: walks a job's masks and issues one key event a cycle while the output is not stalled.
module kmce_back
    import kmce_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       job_valid,
    output logic       job_stall,
    input  job_t       job,
    output logic       key_event_valid,
    input  logic       key_event_stall,
    output key_event_t key_event
);

    logic                busy_reg, busy_next;
    logic [KEY_W-1:0]    base_reg;
    logic [MAX_ROWS-1:0] press_reg, press_next;
    logic [MAX_ROWS-1:0] release_reg, release_next;
    logic                out_valid_reg, out_valid_next;
    key_event_t          out_reg, out_next;

    logic                 out_free;
    logic                 take_job;
    logic                 emit;
    logic                 sel_press;
    logic [MAX_ROWS-1:0]  cur_mask;
    logic [MAX_ROWS-1:0]  rest_mask;
    logic [ROW_IDX_W-1:0] row_idx;
    logic                 is_last;

    assign out_free  = !out_valid_reg || !key_event_stall;
    assign job_stall = busy_reg;
    assign take_job  = job_valid && !busy_reg;
    assign emit      = busy_reg && out_free;

    // Presses first, then releases, each in ascending row order.
    assign sel_press = (press_reg != '0);
    assign cur_mask  = sel_press ? press_reg : release_reg;
    assign row_idx   = lowest_set(cur_mask);
    assign rest_mask = cur_mask & (cur_mask - 1'b1);
    assign is_last   = (rest_mask == '0) && (!sel_press || (release_reg == '0));

    always_comb
    begin
        busy_next      = busy_reg;
        press_next     = press_reg;
        release_next   = release_reg;
        out_valid_next = out_valid_reg && key_event_stall;
        out_next       = out_reg;
        if (take_job)
        begin
            busy_next    = 1'b1;
            press_next   = job.down_rows;
            release_next = job.up_rows;
        end
        else if (emit)
        begin
            if (sel_press)
            begin
                press_next = rest_mask;
            end
            else
            begin
                release_next = rest_mask;
            end
            busy_next          = !is_last;
            out_valid_next     = 1'b1;
            out_next.key_index = base_reg + KEY_W'(row_idx);
            out_next.pressed   = sel_press;
            out_next.last      = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        press_reg   <= press_next;
        release_reg <= release_next;
        out_reg     <= out_next;
        if (take_job)
        begin
            base_reg <= job.base;
        end
    end

    assign key_event_valid = out_valid_reg;
    assign key_event       = out_reg;

endmodule

### rtl/keypad_matrix_change_events.sv
// Keypad matrix change detector. Each accepted reading (one column's active-low
// row levels) is compared with the pressed mask stored for that column, and one
// key event is issued for each newly pressed row in ascending order, then for
// each newly released row, with last set on the final one. A reading that
// changes nothing, or names a column at or above column_count, gives no event.
// The front end classifies each reading and hands its changes to a two-entry
// job queue; readings are taken every cycle until that queue is full.
// The event sequencer loads a job and then issues one event per cycle while
// the output is not stalled, and takes no new job until the last event of the
// current one has been issued.
module keypad_matrix_change_events
    import kmce_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write,
    input  cfg_reg_t         cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             reading_valid,
    output logic             reading_stall,
    input  reading_t         reading,
    output logic             key_event_valid,
    input  logic             key_event_stall,
    output key_event_t       key_event
);

    logic front_valid;
    logic front_stall;
    job_t front_job;
    logic back_valid;
    logic back_stall;
    job_t back_job;

    kmce_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .reading_valid (reading_valid),
        .reading_stall (reading_stall),
        .reading       (reading),
        .job_valid     (front_valid),
        .job_stall     (front_stall),
        .job           (front_job)
    );

    kmce_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_stall (front_stall),
        .push_job   (front_job),
        .pop_valid  (back_valid),
        .pop_stall  (back_stall),
        .pop_job    (back_job)
    );

    kmce_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .job_valid       (back_valid),
        .job_stall       (back_stall),
        .job             (back_job),
        .key_event_valid (key_event_valid),
        .key_event_stall (key_event_stall),
        .key_event       (key_event)
    );

endmodule

### rtl/kmce_chk.sv
// Port-level checker for the keypad change detector, bound to the top level.
module kmce_chk
    import kmce_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       key_event_valid,
    input logic       key_event_stall,
    input key_event_t key_event
);

    // A stalled event holds.
    a_event_hold: assert property (@(posedge clk) disable iff (!rst_n)
        key_event_valid && key_event_stall |=> key_event_valid && $stable(key_event))
        else $error("key event changed while stalled");

    // Events of one item come out back to back once taken.
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        key_event_valid && !key_event_stall && !key_event.last |=> key_event_valid)
        else $error("gap inside an item's events");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        key_event_valid |-> key_event.key_index < KEY_W'(MAX_ROWS * MAX_COLUMNS))
        else $error("key index out of range");

    // Come out of reset with nothing on the output.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !key_event_valid)
        else $error("event shown straight after reset");

endmodule

bind keypad_matrix_change_events kmce_chk u_kmce_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .key_event_valid (key_event_valid),
    .key_event_stall (key_event_stall),
    .key_event       (key_event)
);
